[rtl/rth_pkg.sv]
package rth_pkg;

	// Fixed-point scale of hue: 60 degrees in 1/64 degree units
	localparam logic [11:0] HUE_SCALE = 12'd3840;
	localparam logic [14:0] HUE_GREEN = 15'd7680;
	localparam logic [14:0] HUE_BLUE  = 15'd15360;
	localparam logic [14:0] HUE_FULL  = 15'd23040;

	// Divider geometry: quotient bits and steps done per pipeline stage
	localparam int HUE_BITS        = 12;
	localparam int SAT_BITS        = 16;
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = SAT_BITS / STEPS_PER_STAGE;
	localparam int HUE_STAGES      = HUE_BITS / STEPS_PER_STAGE;

	// Which component is the largest
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sect_t;

	// Per-item facts carried alongside the dividers
	typedef struct packed {
		logic        gray;
		logic        neg;
		sect_t       sect;
		logic [8:0]  sum;
	} side_t;

	typedef struct packed {
		logic [7:0]          den;
		logic [7:0]          rem;
		logic [HUE_BITS-1:0] low;
		logic [HUE_BITS-1:0] quo;
	} hue_div_t;

	typedef struct packed {
		logic [7:0]          den;
		logic [7:0]          rem;
		logic [SAT_BITS-1:0] low;
		logic [SAT_BITS-1:0] quo;
	} sat_div_t;

	typedef struct packed {
		side_t    side;
		hue_div_t hue;
		sat_div_t sat;
	} div_item_t;

	// One restoring division step of the hue divider
	function automatic hue_div_t hue_step(hue_div_t d);
		hue_div_t   n;
		logic [8:0] t;
		logic       ge;
		t     = {d.rem, d.low[HUE_BITS-1]};
		ge    = (t >= {1'b0, d.den});
		n.den = d.den;
		n.rem = ge ? 8'(t - {1'b0, d.den}) : t[7:0];
		n.low = {d.low[HUE_BITS-2:0], 1'b0};
		n.quo = {d.quo[HUE_BITS-2:0], ge};
		return n;
	endfunction

	// One restoring division step of the saturation divider
	function automatic sat_div_t sat_step(sat_div_t d);
		sat_div_t   n;
		logic [8:0] t;
		logic       ge;
		t     = {d.rem, d.low[SAT_BITS-1]};
		ge    = (t >= {1'b0, d.den});
		n.den = d.den;
		n.rem = ge ? 8'(t - {1'b0, d.den}) : t[7:0];
		n.low = {d.low[SAT_BITS-2:0], 1'b0};
		n.quo = {d.quo[SAT_BITS-2:0], ge};
		return n;
	endfunction

endpackage

[rtl/rth_front.sv]
module rth_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rth_pkg::div_item_t   out_item
);

	logic                valid_s1;
	rth_pkg::side_t      side_s1;
	logic [7:0]          absdiff_s1;
	logic [7:0]          delta_s1;
	logic                valid_s2;
	rth_pkg::div_item_t  item_s2;

	logic                rdy_s1;
	logic                rdy_s2;
	rth_pkg::side_t      side_c;
	logic [7:0]          mx_c;
	logic [7:0]          mn_c;
	logic [7:0]          opa_c;
	logic [7:0]          opb_c;
	logic [7:0]          absdiff_c;
	rth_pkg::div_item_t  item_c;
	logic [19:0]         hnum_c;
	logic [8:0]          den_c;

	assign rdy_s2   = !valid_s2 || out_ready;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Find largest and smallest component and the hue difference operands
	always_comb begin
		if (red >= green && red >= blue) begin
			side_c.sect = rth_pkg::SECT_RED;
			mx_c        = red;
			opa_c       = green;
			opb_c       = blue;
		end else if (green >= blue) begin
			side_c.sect = rth_pkg::SECT_GREEN;
			mx_c        = green;
			opa_c       = blue;
			opb_c       = red;
		end else begin
			side_c.sect = rth_pkg::SECT_BLUE;
			mx_c        = blue;
			opa_c       = red;
			opb_c       = green;
		end
		mn_c = (red <= green) ? red : green;
		mn_c = (mn_c <= blue) ? mn_c : blue;
		side_c.neg  = opa_c < opb_c;
		absdiff_c   = side_c.neg ? (opb_c - opa_c) : (opa_c - opb_c);
		side_c.sum  = {1'b0, mx_c} + {1'b0, mn_c};
		side_c.gray = (mx_c == mn_c);
	end

	// Stage 1: extremes and differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			side_s1    <= side_c;
			absdiff_s1 <= absdiff_c;
			delta_s1   <= mx_c - mn_c;
		end
	end

	// Scale the hue numerator and pick the saturation divisor
	always_comb begin
		hnum_c         = 20'(absdiff_s1) * 20'(rth_pkg::HUE_SCALE);
		den_c          = (side_s1.sum <= 9'd255) ? side_s1.sum : (9'd510 - side_s1.sum);
		item_c.side    = side_s1;
		item_c.hue.den = delta_s1;
		item_c.hue.rem = hnum_c[19:12];
		item_c.hue.low = hnum_c[11:0];
		item_c.hue.quo = '0;
		item_c.sat.den = den_c[7:0];
		item_c.sat.rem = {1'b0, delta_s1[7:1]};
		item_c.sat.low = {delta_s1[0], 15'd0};
		item_c.sat.quo = '0;
	end

	// Stage 2: loaded dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && rdy_s2) begin
			item_s2 <= item_c;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

[rtl/rth_div_stage.sv]
module rth_div_stage #(
	parameter int HUE_STEPS = 2,
	parameter int SAT_STEPS = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rth_pkg::div_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output rth_pkg::div_item_t  out_item
);

	logic                valid_sd;
	rth_pkg::div_item_t  item_sd;
	rth_pkg::div_item_t  nxt_c;

	assign in_ready = !valid_sd || out_ready;

	// Advance both dividers by this stage's share of steps
	always_comb begin
		nxt_c = in_item;
		for (int k = 0; k < HUE_STEPS; k++) begin
			nxt_c.hue = rth_pkg::hue_step(nxt_c.hue);
		end
		for (int k = 0; k < SAT_STEPS; k++) begin
			nxt_c.sat = rth_pkg::sat_step(nxt_c.sat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd <= 1'b0;
		end else if (in_ready) begin
			valid_sd <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_sd <= nxt_c;
		end
	end

	assign out_valid = valid_sd;
	assign out_item  = item_sd;

`ifndef NO_ASSERTIONS
	// Partial remainders stay below their divisors
	a_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_sd && !item_sd.side.gray |-> item_sd.sat.rem < item_sd.sat.den)
		else $error("saturation remainder not below divisor");
	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_sd && !item_sd.side.gray |-> item_sd.hue.rem < item_sd.hue.den)
		else $error("hue remainder not below divisor");
`endif

endmodule

[rtl/rth_back.sv]
module rth_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rth_pkg::div_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [14:0]         hue,
	output logic [15:0]         sat,
	output logic [8:0]          light
);

	logic         valid_s11;
	logic [14:0]  hue_s11;
	logic [15:0]  sat_s11;
	logic [8:0]   light_s11;

	logic [14:0]  base_c;
	logic [14:0]  hue_c;
	logic         inexact_c;

	assign in_ready = !valid_s11 || out_ready;

	// Place the fraction within its sector (gray gives zero); round a negative offset up in magnitude
	always_comb begin
		unique case (in_item.side.sect)
			rth_pkg::SECT_RED:   base_c = in_item.side.neg ? rth_pkg::HUE_FULL : 15'd0;
			rth_pkg::SECT_GREEN: base_c = rth_pkg::HUE_GREEN;
			rth_pkg::SECT_BLUE:  base_c = rth_pkg::HUE_BLUE;
			default:             base_c = 15'd0;
		endcase
		inexact_c = (in_item.hue.rem != 8'd0);
		if (in_item.side.gray) begin
			hue_c = 15'd0;
		end else if (in_item.side.neg) begin
			hue_c = base_c - 15'(in_item.hue.quo) - 15'(inexact_c);
		end else begin
			hue_c = base_c + 15'(in_item.hue.quo);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else if (in_ready) begin
			valid_s11 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hue_s11   <= hue_c;
			sat_s11   <= in_item.side.gray ? 16'd0 : in_item.sat.quo;
			light_s11 <= in_item.side.sum;
		end
	end

	assign out_valid = valid_s11;
	assign hue       = hue_s11;
	assign sat       = sat_s11;
	assign light     = light_s11;

`ifndef NO_ASSERTIONS
	// Results stay in their legal ranges
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s11 |-> hue_s11 < rth_pkg::HUE_FULL)
		else $error("hue out of range");
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s11 |-> sat_s11 <= 16'd32768)
		else $error("saturation out of range");
`endif

endmodule

[rtl/rgb_to_hsl.sv]
// RGB to HSL converter, one pixel item per clock while the output is not stalled.
// Pipeline: 2 front stages, 8 divider stages doing two restoring steps each
// for saturation, 1 output register; the 16-step saturation divide sets depth.
// Throughput: one item per cycle while hsl_ready is high.
// Reset: arst_n asynchronously clears all stage valid bits; data is not reset.
module rgb_to_hsl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pix_valid,
	output logic         pix_ready,
	input  logic [7:0]   red,
	input  logic [7:0]   green,
	input  logic [7:0]   blue,
	output logic         hsl_valid,
	input  logic         hsl_ready,
	output logic [14:0]  hue_sixtyfourths,
	output logic [15:0]  saturation_q15,
	output logic [8:0]   lightness_sum
);

	logic                chain_valid [0:rth_pkg::DIV_STAGES];
	logic                chain_ready [0:rth_pkg::DIV_STAGES];
	rth_pkg::div_item_t  chain_item  [0:rth_pkg::DIV_STAGES];

	// Extremes, differences and divider setup
	rth_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_valid),
		.in_ready  (pix_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_item  (chain_item[0])
	);

	// Divider pipeline; hue finishes early and passes through the rest
	for (genvar i = 0; i < rth_pkg::DIV_STAGES; i++) begin : g_div
		localparam int HS = (i < rth_pkg::HUE_STAGES) ? rth_pkg::STEPS_PER_STAGE : 0;
		rth_div_stage #(
			.HUE_STEPS (HS),
			.SAT_STEPS (rth_pkg::STEPS_PER_STAGE)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_item   (chain_item[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_item  (chain_item[i+1])
		);
	end

	// Hue assembly and output register
	rth_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[rth_pkg::DIV_STAGES]),
		.in_ready  (chain_ready[rth_pkg::DIV_STAGES]),
		.in_item   (chain_item[rth_pkg::DIV_STAGES]),
		.out_valid (hsl_valid),
		.out_ready (hsl_ready),
		.hue       (hue_sixtyfourths),
		.sat       (saturation_q15),
		.light     (lightness_sum)
	);

endmodule
